FILE: hw/rtl/cpp_pkg.sv
// Shared types and constants for the GPU command packet parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDX_BUFFER_WORDS   = 3'd0;
  localparam logic [2:0] CFG_IDX_DRAW_OP        = 3'd1;
  localparam logic [2:0] CFG_IDX_INLINE_DRAW_OP = 3'd2;
  localparam logic [2:0] CFG_IDX_INDIRECT_OP    = 3'd3;
  localparam logic [2:0] CFG_IDX_INDIRECT_PFD_OP = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RST_BUFFER_WORDS    = 32'd0;
  localparam logic [6:0]  RST_DRAW_OP         = 7'd34;
  localparam logic [6:0]  RST_INLINE_DRAW_OP  = 7'd54;
  localparam logic [6:0]  RST_INDIRECT_OP     = 7'd63;
  localparam logic [6:0]  RST_INDIRECT_PFD_OP = 7'd55;

  // Packet header types (header bits 31:30)
  localparam logic [1:0] HDR_TYPE0 = 2'd0;
  localparam logic [1:0] HDR_TYPE1 = 2'd1;
  localparam logic [1:0] HDR_TYPE2 = 2'd2;

  // Draw index source codes
  localparam logic [1:0] SRC_NONE    = 2'd0;
  localparam logic [1:0] SRC_INDEXED = 2'd1;
  localparam logic [1:0] SRC_AUTO    = 2'd2;
  localparam logic [1:0] SRC_INLINE  = 2'd3;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_REG_WRITE  = 3'd0,
    KIND_DRAW       = 3'd1,
    KIND_INDIRECT   = 3'd2,
    KIND_RAW        = 3'd3,
    KIND_FILLER     = 3'd4,
    KIND_INCOMPLETE = 3'd5
  } kind_t;

  // Class of the packet in progress
  typedef enum logic [2:0] {
    CLS_REGRUN   = 3'd0,
    CLS_REGPAIR  = 3'd1,
    CLS_RAW      = 3'd3,
    CLS_DRAW     = 3'd4,
    CLS_INLINE   = 3'd5,
    CLS_INDIRECT = 3'd6
  } cls_t;

  typedef struct packed {
    logic [31:0] buffer_words;
    logic [6:0]  draw_op;
    logic [6:0]  inline_draw_op;
    logic [6:0]  indirect_op;
    logic [6:0]  indirect_pfd_op;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        last_in_packet;
    logic [14:0] reg_index;
    logic [31:0] data_value;
    logic [31:0] aux_value;
    logic [6:0]  cmd_opcode;
    logic        predicated;
    logic [15:0] draw_count;
    logic [5:0]  primitive_res;
    logic        index_wide;
    logic [1:0]  draw_source;
    logic [1:0]  draw_endian;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpp_parser.sv
// Packet state registers and per-dword decode of the command parser.
// Depends on cpp_pkg (cfg_t, result_t, cls_t, kind_t, header constants).
`timescale 1ns / 1ps
`default_nettype none

module cpp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [31:0]      word,
  input  wire logic             first,
  input  wire cpp_pkg::cfg_t    cfg,
  output logic                  res_valid,
  output cpp_pkg::result_t      res,
  output logic                  stopped
);
  import cpp_pkg::*;

  logic [31:0] position_r, position_nxt;
  logic [31:0] header_pos_r, header_pos_nxt;
  logic [14:0] words_left_r, words_left_nxt;
  logic [14:0] payload_total_r, payload_total_nxt;
  cls_t        class_r, class_nxt;
  logic [14:0] reg_cursor_r, reg_cursor_nxt;
  logic [10:0] second_index_r, second_index_nxt;
  logic        repeat_same_r, repeat_same_nxt;
  logic [6:0]  held_op_r, held_op_nxt;
  logic        held_pred_r, held_pred_nxt;
  logic [31:0] draw_params_r, draw_params_nxt;
  logic [31:0] cap_a_r, cap_a_nxt;
  logic [31:0] cap_b_r, cap_b_nxt;
  logic        stopped_r, stopped_nxt;

  // Restart handling: first_word drops the packet and clears the stop
  logic [31:0] pos_eff;
  logic [14:0] wl_eff;
  logic        stop_eff;
  assign pos_eff  = first ? 32'd0 : position_r;
  assign wl_eff   = first ? 15'd0 : words_left_r;
  assign stop_eff = first ? 1'b0  : stopped_r;

  // Header fields and the fit check against the buffer length
  logic [1:0]  hdr_type;
  logic [14:0] hdr_count;
  logic [32:0] hdr_end;
  logic        hdr_overflow;
  logic [6:0]  hdr_op;
  logic [31:0] room_words;
  assign hdr_type     = word[31:30];
  assign hdr_count    = (hdr_type == HDR_TYPE1) ? 15'd2 : ({1'b0, word[29:16]} + 15'd1);
  assign hdr_end      = {1'b0, pos_eff} + 33'd1 + {18'd0, hdr_count};
  assign hdr_overflow = hdr_end > {1'b0, cfg.buffer_words};
  assign hdr_op       = word[14:8];
  assign room_words   = cfg.buffer_words - pos_eff;

  // Payload word position within the packet
  logic [14:0] idx;
  logic [14:0] wl_dec;
  logic        last;
  assign idx    = payload_total_r - wl_eff;
  assign wl_dec = wl_eff - 15'd1;
  assign last   = (wl_dec == 15'd0);

  // Decode and next state
  always_comb begin
    logic [31:0] dp;
    logic [31:0] ca;
    logic [31:0] cb;
    dp = draw_params_r;
    ca = cap_a_r;
    cb = cap_b_r;

    position_nxt      = pos_eff;
    header_pos_nxt    = header_pos_r;
    words_left_nxt    = wl_eff;
    payload_total_nxt = payload_total_r;
    class_nxt         = class_r;
    reg_cursor_nxt    = reg_cursor_r;
    second_index_nxt  = second_index_r;
    repeat_same_nxt   = repeat_same_r;
    held_op_nxt       = held_op_r;
    held_pred_nxt     = held_pred_r;
    draw_params_nxt   = draw_params_r;
    cap_a_nxt         = cap_a_r;
    cap_b_nxt         = cap_b_r;
    stopped_nxt       = stop_eff;
    res               = '0;
    res_valid         = 1'b0;

    if (!stop_eff && (pos_eff < cfg.buffer_words)) begin
      position_nxt = pos_eff + 32'd1;
      if (wl_eff == 15'd0) begin
        // header word
        if (hdr_type == HDR_TYPE2) begin
          res_valid          = 1'b1;
          res.kind           = KIND_FILLER;
          res.last_in_packet = 1'b1;
        end else if (hdr_overflow) begin
          res_valid          = 1'b1;
          res.kind           = KIND_INCOMPLETE;
          res.last_in_packet = 1'b1;
          res.data_value     = {room_words[29:0], 2'b00};
          res.aux_value      = {15'd0, hdr_count + 15'd1, 2'b00};
          stopped_nxt        = 1'b1;
        end else begin
          header_pos_nxt    = pos_eff;
          words_left_nxt    = hdr_count;
          payload_total_nxt = hdr_count;
          if (hdr_type == HDR_TYPE0) begin
            class_nxt       = CLS_REGRUN;
            reg_cursor_nxt  = word[14:0];
            repeat_same_nxt = word[15];
          end else if (hdr_type == HDR_TYPE1) begin
            class_nxt        = CLS_REGPAIR;
            reg_cursor_nxt   = {4'd0, word[10:0]};
            second_index_nxt = word[21:11];
          end else begin
            held_op_nxt     = hdr_op;
            held_pred_nxt   = word[0];
            draw_params_nxt = '0;
            cap_a_nxt       = '0;
            cap_b_nxt       = '0;
            priority if (hdr_op == cfg.draw_op) begin
              class_nxt = CLS_DRAW;
            end else if (hdr_op == cfg.inline_draw_op) begin
              class_nxt = CLS_INLINE;
            end else if (((hdr_op == cfg.indirect_op) || (hdr_op == cfg.indirect_pfd_op))
                         && (hdr_count >= 15'd2)) begin
              class_nxt = CLS_INDIRECT;
            end else begin
              class_nxt = CLS_RAW;
            end
          end
        end
      end else begin
        // payload word
        words_left_nxt = wl_dec;
        unique case (class_r)
          CLS_REGRUN: begin
            res_valid          = 1'b1;
            res.kind           = KIND_REG_WRITE;
            res.last_in_packet = last;
            res.reg_index      = reg_cursor_r;
            res.data_value     = word;
            if (!repeat_same_r) begin
              reg_cursor_nxt = reg_cursor_r + 15'd1;
            end
          end
          CLS_REGPAIR: begin
            res_valid          = 1'b1;
            res.kind           = KIND_REG_WRITE;
            res.last_in_packet = last;
            res.reg_index      = (idx == 15'd0) ? reg_cursor_r : {4'd0, second_index_r};
            res.data_value     = word;
          end
          CLS_DRAW: begin
            if (idx == 15'd1) dp = word;
            if (idx == 15'd2) ca = word;
            if (idx == 15'd3) cb = word;
            draw_params_nxt = dp;
            cap_a_nxt       = ca;
            cap_b_nxt       = cb;
            if (last) begin
              res_valid          = 1'b1;
              res.kind           = KIND_DRAW;
              res.last_in_packet = 1'b1;
              res.cmd_opcode     = held_op_r;
              res.predicated     = held_pred_r;
              if (payload_total_r >= 15'd2) begin
                res.draw_count    = dp[31:16];
                res.primitive_res = dp[5:0];
                res.index_wide    = dp[11];
                if ((dp[7:6] == SRC_NONE) && (payload_total_r >= 15'd4)) begin
                  res.draw_source = SRC_INDEXED;
                  res.data_value  = ca;
                  res.aux_value   = dp[11] ? {6'd0, cb[23:0], 2'b00}
                                           : {7'd0, cb[23:0], 1'b0};
                  res.draw_endian = cb[31:30];
                end else begin
                  res.draw_source = SRC_AUTO;
                end
              end
            end
          end
          CLS_INLINE: begin
            if (idx == 15'd0) dp = word;
            draw_params_nxt = dp;
            if (last) begin
              res_valid          = 1'b1;
              res.kind           = KIND_DRAW;
              res.last_in_packet = 1'b1;
              res.aux_value      = header_pos_r + 32'd2;
              res.cmd_opcode     = held_op_r;
              res.predicated     = held_pred_r;
              res.draw_count     = dp[31:16];
              res.primitive_res  = dp[5:0];
              res.index_wide     = dp[11];
              res.draw_source    = SRC_INLINE;
            end
          end
          CLS_INDIRECT: begin
            if (idx == 15'd0) ca = word;
            if (idx == 15'd1) cb = word;
            cap_a_nxt = ca;
            cap_b_nxt = cb;
            if (last) begin
              res_valid          = 1'b1;
              res.kind           = KIND_INDIRECT;
              res.last_in_packet = 1'b1;
              res.data_value     = ca;
              res.aux_value      = cb;
              res.cmd_opcode     = held_op_r;
              res.predicated     = held_pred_r;
            end
          end
          default: begin
            // raw command payload, one result per word
            res_valid          = 1'b1;
            res.kind           = KIND_RAW;
            res.last_in_packet = last;
            res.data_value     = word;
            res.cmd_opcode     = held_op_r;
            res.predicated     = held_pred_r;
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      words_left_r <= '0;
      stopped_r    <= 1'b0;
      class_r      <= CLS_REGRUN;
    end else if (in_fire) begin
      position_r   <= position_nxt;
      words_left_r <= words_left_nxt;
      stopped_r    <= stopped_nxt;
      class_r      <= class_nxt;
    end
  end

  // Packet payload state, always written by a header before use
  always_ff @(posedge clk) begin
    if (in_fire) begin
      header_pos_r    <= header_pos_nxt;
      payload_total_r <= payload_total_nxt;
      reg_cursor_r    <= reg_cursor_nxt;
      second_index_r  <= second_index_nxt;
      repeat_same_r   <= repeat_same_nxt;
      held_op_r       <= held_op_nxt;
      held_pred_r     <= held_pred_nxt;
      draw_params_r   <= draw_params_nxt;
      cap_a_r         <= cap_a_nxt;
      cap_b_r         <= cap_b_nxt;
    end
  end

  assign stopped = stopped_r;

endmodule

`default_nettype wire

FILE: hw/rtl/cpp_out_reg.sv
// Result register of the command parser; holds one result until taken.
// Depends on cpp_pkg (result_t).
`timescale 1ns / 1ps
`default_nettype none

module cpp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic             res_valid,
  input  wire cpp_pkg::result_t res,
  input  wire logic             take,
  output logic                  valid,
  output cpp_pkg::result_t      data
);
  import cpp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // A new request replaces the held result; otherwise a take empties it
  always_comb begin
    if (in_fire) begin
      valid_nxt = res_valid;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      data_r <= res;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/gpu_command_packet_parser.sv
// GPU command packet parser, top level: configuration registers, stream ports.
// Depends on cpp_pkg, cpp_parser and cpp_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one big-endian command dword per clock and produces at most one result
// per dword, in the next cycle, from a single result register. A new dword is
// accepted in every cycle in which the result register is empty or being taken,
// so the sustained rate is one dword per clock; only a stalled result side
// slows it. Headers are checked against buffer_words before any result of the
// packet is emitted; a packet that does not fit gives an incomplete result and
// everything after it is ignored until a dword marked as first word. Register
// writes take effect on the next request and are meant for idle periods.

module gpu_command_packet_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] word_data
  input  wire logic         in_tuser,   // [0] first_word
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [14:0] reg_index, [46:15] data_value, [78:47] aux_value, [85:79] cmd_opcode,
  // [86] predicated, [102:87] draw_count, [108:103] primitive_res,
  // [109] index_wide, [111:110] draw_source, [113:112] draw_endian, rest zero
  output logic [119:0]      out_tdata,
  output logic [2:0]        out_tuser,  // [2:0] kind
  output logic              out_tlast,  // last_in_packet
  // configuration
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import cpp_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    stopped;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_BUFFER_WORDS:    cfg_nxt.buffer_words    = cfg_wdata;
        CFG_IDX_DRAW_OP:         cfg_nxt.draw_op         = cfg_wdata[6:0];
        CFG_IDX_INLINE_DRAW_OP:  cfg_nxt.inline_draw_op  = cfg_wdata[6:0];
        CFG_IDX_INDIRECT_OP:     cfg_nxt.indirect_op     = cfg_wdata[6:0];
        CFG_IDX_INDIRECT_PFD_OP: cfg_nxt.indirect_pfd_op = cfg_wdata[6:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_words    <= RST_BUFFER_WORDS;
      cfg_r.draw_op         <= RST_DRAW_OP;
      cfg_r.inline_draw_op  <= RST_INLINE_DRAW_OP;
      cfg_r.indirect_op     <= RST_INDIRECT_OP;
      cfg_r.indirect_pfd_op <= RST_INDIRECT_PFD_OP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept while the result register is free or draining
  assign in_tready = !out_tvalid || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  cpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .word      (in_tdata),
    .first     (in_tuser),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .stopped   (stopped)
  );

  cpp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .res_valid (res_valid),
    .res       (res),
    .take      (out_tready),
    .valid     (out_tvalid),
    .data      (out_res)
  );

  // Pack the result
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last_in_packet;
  assign out_tdata = {6'd0, out_res.draw_endian, out_res.draw_source, out_res.index_wide,
                      out_res.primitive_res, out_res.draw_count, out_res.predicated,
                      out_res.cmd_opcode, out_res.aux_value, out_res.data_value,
                      out_res.reg_index};

`ifndef SYNTHESIS
  // Filler, draw, indirect and incomplete results always close their packet
  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_FILLER || out_tuser == KIND_DRAW ||
                    out_tuser == KIND_INDIRECT || out_tuser == KIND_INCOMPLETE))
    |-> out_tlast)
    else $error("single-result packet without tlast");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Once stopped, words without a restart produce nothing
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && stopped && !in_tuser) |=> !out_tvalid)
    else $error("result produced after incomplete packet");
`endif

endmodule

`default_nettype wire
